[hdl/wtrm_pkg.sv]
// Shared types and constants for the windowed traffic rate meter.
`default_nettype none

package wtrm_pkg;

  // Widths fixed by the transaction fields and the window registers.
  localparam int DATA_W    = 32;
  localparam int TOT_W     = DATA_W + 1;
  localparam int WIN_W     = 6;
  localparam int NUM_WIN   = 3;
  localparam int NUM_LANE  = 2 * NUM_WIN;
  // A window never covers more than 63 entries, so a sum needs six extra bits.
  localparam int SUM_W     = DATA_W + WIN_W;
  // Divisor is at most 63 times a scale of at most 31.
  localparam int SCALE_W   = 5;
  localparam int DVS_W     = WIN_W + SCALE_W;
  localparam int DCNT_W    = $clog2(SUM_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LONG  = 2'd2;

  localparam logic [WIN_W-1:0] WIN_SHORT_RST = 6'd1;
  localparam logic [WIN_W-1:0] WIN_MID_RST   = 6'd5;
  localparam logic [WIN_W-1:0] WIN_LONG_RST  = 6'd20;

  typedef struct packed {
    logic accept;
    logic walk_step;
    logic div_load;
    logic div_step;
    logic load_out;
  } wtrm_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic div_last;
  } wtrm_sts_t;

endpackage

`default_nettype wire

[hdl/wtrm_ctrl.sv]
// Sequencing state machine of the windowed traffic rate meter.
`default_nettype none

module wtrm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wtrm_pkg::wtrm_cmd_t     cmd,
  input  wire wtrm_pkg::wtrm_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Wait here until the previous result has left the output register.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_divide_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE && !sts.div_last) |=> (state_r == ST_DIVIDE))
    else $error("divide phase left early");

  a_walk_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && sts.walk_last) |=> (state_r == ST_DRAIN))
    else $error("walk did not end in drain");

endmodule

`default_nettype wire

[hdl/wtrm_dp.sv]
// Datapath of the windowed traffic rate meter: ring memory, window sums, peaks, divider lanes.
`default_nettype none

module wtrm_dp #(
  parameter int RING_DEPTH     = 32,
  parameter int INTERVAL_SCALE = 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire wtrm_pkg::wtrm_cmd_t                    cmd,
  output wtrm_pkg::wtrm_sts_t                         sts,
  input  wire logic                                   cfg_we,
  input  wire logic [wtrm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [wtrm_pkg::WIN_W-1:0]             cfg_data,
  input  wire logic [wtrm_pkg::DATA_W-1:0]            in_sent_bytes,
  input  wire logic [wtrm_pkg::DATA_W-1:0]            in_recv_bytes,
  output logic [wtrm_pkg::DATA_W-1:0]                 out_avg_sent_short,
  output logic [wtrm_pkg::DATA_W-1:0]                 out_avg_sent_mid,
  output logic [wtrm_pkg::DATA_W-1:0]                 out_avg_sent_long,
  output logic [wtrm_pkg::DATA_W-1:0]                 out_avg_recv_short,
  output logic [wtrm_pkg::DATA_W-1:0]                 out_avg_recv_mid,
  output logic [wtrm_pkg::DATA_W-1:0]                 out_avg_recv_long,
  output logic [wtrm_pkg::DATA_W-1:0]                 out_peak_sent,
  output logic [wtrm_pkg::DATA_W-1:0]                 out_peak_recv,
  output logic [wtrm_pkg::TOT_W-1:0]                  out_peak_total
);

  localparam int DATA_W   = wtrm_pkg::DATA_W;
  localparam int TOT_W    = wtrm_pkg::TOT_W;
  localparam int WIN_W    = wtrm_pkg::WIN_W;
  localparam int SUM_W    = wtrm_pkg::SUM_W;
  localparam int DVS_W    = wtrm_pkg::DVS_W;
  localparam int DCNT_W   = wtrm_pkg::DCNT_W;
  localparam int NUM_WIN  = wtrm_pkg::NUM_WIN;
  localparam int NUM_LANE = wtrm_pkg::NUM_LANE;
  localparam int AGE_W    = $clog2(RING_DEPTH);
  localparam int FILL_W   = $clog2(RING_DEPTH + 1);
  localparam int CMP_W    = (FILL_W > WIN_W) ? FILL_W : WIN_W;

  localparam logic [AGE_W-1:0]  LAST_SLOT = AGE_W'(RING_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(RING_DEPTH);
  localparam logic [DCNT_W-1:0] LAST_BIT  = DCNT_W'(SUM_W - 1);
  localparam logic [DVS_W-1:0]  SCALE     = DVS_W'(INTERVAL_SCALE);

  // Ring memory: one entry holds the sent count above the received count.
  logic [2*DATA_W-1:0] ring_mem [RING_DEPTH];
  logic [2*DATA_W-1:0] rd_data_r;

  logic [WIN_W-1:0]  win_r [NUM_WIN];
  logic [AGE_W-1:0]  newest_r, newest_nxt;
  logic [AGE_W-1:0]  ptr_r;
  logic [AGE_W-1:0]  age_r;
  logic [AGE_W-1:0]  rd_age_r;
  logic              rd_vld_r;
  logic              rd_live_r;
  logic [FILL_W-1:0] fill_r;

  logic [SUM_W-1:0]  acc_r [NUM_LANE];
  logic [DVS_W-1:0]  rem_r [NUM_LANE];
  logic [DVS_W-1:0]  dvs_r [NUM_WIN];
  logic              dvs_zero_r [NUM_WIN];
  logic [DCNT_W-1:0] dcnt_r;

  logic [DATA_W-1:0] pk_sent_r, pk_recv_r;
  logic [TOT_W-1:0]  pk_total_r;

  logic [DATA_W-1:0] ent_sent, ent_recv;
  logic [TOT_W-1:0]  ent_total;
  logic              in_win [NUM_WIN];
  logic [WIN_W-1:0]  len [NUM_WIN];
  logic [DVS_W-1:0]  dvs [NUM_WIN];
  logic [DVS_W:0]    rem_sh [NUM_LANE];
  logic [DVS_W:0]    diff [NUM_LANE];
  logic              qbit [NUM_LANE];
  logic [DVS_W-1:0]  rem_nxt [NUM_LANE];
  logic [DATA_W-1:0] avg [NUM_LANE];

  assign newest_nxt    = (newest_r == LAST_SLOT) ? '0 : newest_r + 1'b1;
  assign sts.walk_last = (age_r == LAST_SLOT);
  assign sts.div_last  = (dcnt_r == LAST_BIT);

  // Slots at or beyond the fill count were never written and read as zero.
  assign ent_sent  = rd_live_r ? rd_data_r[2*DATA_W-1:DATA_W] : '0;
  assign ent_recv  = rd_live_r ? rd_data_r[DATA_W-1:0] : '0;
  assign ent_total = {1'b0, ent_sent} + {1'b0, ent_recv};

  always_comb begin
    for (int k = 0; k < NUM_WIN; k++) begin
      in_win[k] = CMP_W'(rd_age_r) < CMP_W'(win_r[k]);
      len[k]    = (CMP_W'(fill_r) < CMP_W'(win_r[k])) ? WIN_W'(fill_r) : win_r[k];
      dvs[k]    = DVS_W'(len[k]) * SCALE;
    end
  end

  // One restoring division step per lane; lanes below NUM_WIN hold sent sums.
  always_comb begin
    for (int l = 0; l < NUM_LANE; l++) begin
      rem_sh[l]  = {rem_r[l], acc_r[l][SUM_W-1]};
      diff[l]    = rem_sh[l] - {1'b0, dvs_r[l % NUM_WIN]};
      qbit[l]    = !diff[l][DVS_W];
      rem_nxt[l] = qbit[l] ? diff[l][DVS_W-1:0] : rem_sh[l][DVS_W-1:0];
      avg[l]     = dvs_zero_r[l % NUM_WIN] ? '0 : acc_r[l][DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[newest_nxt] <= {in_sent_bytes, in_recv_bytes};
    end
    if (cmd.walk_step) begin
      rd_data_r <= ring_mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r[0] <= wtrm_pkg::WIN_SHORT_RST;
      win_r[1] <= wtrm_pkg::WIN_MID_RST;
      win_r[2] <= wtrm_pkg::WIN_LONG_RST;
      newest_r <= LAST_SLOT;
      fill_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wtrm_pkg::CFG_WIN_SHORT: win_r[0] <= cfg_data;
          wtrm_pkg::CFG_WIN_MID:   win_r[1] <= cfg_data;
          wtrm_pkg::CFG_WIN_LONG:  win_r[2] <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        newest_r <= newest_nxt;
        if (fill_r != FULL) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      rd_vld_r <= cmd.walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ptr_r      <= newest_nxt;
      age_r      <= '0;
      pk_sent_r  <= '0;
      pk_recv_r  <= '0;
      pk_total_r <= '0;
      for (int l = 0; l < NUM_LANE; l++) begin
        acc_r[l] <= '0;
      end
    end
    if (cmd.walk_step) begin
      rd_age_r  <= age_r;
      rd_live_r <= CMP_W'(ptr_r) < CMP_W'(fill_r);
      ptr_r     <= (ptr_r == '0) ? LAST_SLOT : ptr_r - 1'b1;
      age_r     <= age_r + 1'b1;
    end
    if (rd_vld_r) begin
      for (int k = 0; k < NUM_WIN; k++) begin
        if (in_win[k]) begin
          acc_r[k]           <= acc_r[k] + SUM_W'(ent_sent);
          acc_r[k + NUM_WIN] <= acc_r[k + NUM_WIN] + SUM_W'(ent_recv);
        end
      end
      if (ent_sent > pk_sent_r) begin
        pk_sent_r <= ent_sent;
      end
      if (ent_recv > pk_recv_r) begin
        pk_recv_r <= ent_recv;
      end
      if (ent_total > pk_total_r) begin
        pk_total_r <= ent_total;
      end
    end
    if (cmd.div_load) begin
      dcnt_r <= '0;
      for (int k = 0; k < NUM_WIN; k++) begin
        dvs_r[k]      <= dvs[k];
        dvs_zero_r[k] <= (dvs[k] == '0);
      end
      for (int l = 0; l < NUM_LANE; l++) begin
        rem_r[l] <= '0;
      end
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      for (int l = 0; l < NUM_LANE; l++) begin
        rem_r[l] <= rem_nxt[l];
        acc_r[l] <= {acc_r[l][SUM_W-2:0], qbit[l]};
      end
    end
    if (cmd.load_out) begin
      out_avg_sent_short <= avg[0];
      out_avg_sent_mid   <= avg[1];
      out_avg_sent_long  <= avg[2];
      out_avg_recv_short <= avg[3];
      out_avg_recv_mid   <= avg[4];
      out_avg_recv_long  <= avg[5];
      out_peak_sent      <= pk_sent_r;
      out_peak_recv      <= pk_recv_r;
      out_peak_total     <= pk_total_r;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond ring depth");

  a_walk_covers_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk_step && sts.walk_last) |->
      (ptr_r == ((newest_r == LAST_SLOT) ? '0 : newest_r + 1'b1)))
    else $error("ring walk did not end next to the newest slot");

endmodule

`default_nettype wire

[hdl/windowed_traffic_rate_meter.sv]
// Top level of the windowed traffic rate meter: state machine plus datapath.
// One transaction at a time: in_ready stays low from acceptance through the ring walk
// (one memory read a cycle) and the 38-step bit-serial divider lanes until the result
// is loaded into the output register.
// A pending result waits in the output register while the next transaction is taken.
// Reset (rst_n low, synchronous): fill count to zero, windows to 1, 5 and 20;
// the ring is not swept, since slots beyond the fill count read as zero.
`default_nettype none

module windowed_traffic_rate_meter #(
  parameter int RING_DEPTH     = 32,
  parameter int INTERVAL_SCALE = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [wtrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wtrm_pkg::WIN_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [wtrm_pkg::DATA_W-1:0]     in_sent_bytes,
  input  wire logic [wtrm_pkg::DATA_W-1:0]     in_recv_bytes,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [wtrm_pkg::DATA_W-1:0]          out_avg_sent_short,
  output logic [wtrm_pkg::DATA_W-1:0]          out_avg_sent_mid,
  output logic [wtrm_pkg::DATA_W-1:0]          out_avg_sent_long,
  output logic [wtrm_pkg::DATA_W-1:0]          out_avg_recv_short,
  output logic [wtrm_pkg::DATA_W-1:0]          out_avg_recv_mid,
  output logic [wtrm_pkg::DATA_W-1:0]          out_avg_recv_long,
  output logic [wtrm_pkg::DATA_W-1:0]          out_peak_sent,
  output logic [wtrm_pkg::DATA_W-1:0]          out_peak_recv,
  output logic [wtrm_pkg::TOT_W-1:0]           out_peak_total
);

  // The controller steps through the phases of one transaction: write the new
  // pair into the ring, walk every slot from newest to oldest, let the last
  // read drain into the sums, load the divider lanes and shift them one
  // quotient bit a cycle, then hand the result to the output register.
  wtrm_pkg::wtrm_cmd_t cmd;
  wtrm_pkg::wtrm_sts_t sts;

  wtrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the ring memory and the window registers. During the
  // walk each read entry is added into every window whose length exceeds its
  // age, and compared against the three running peaks. The six averages are
  // then produced by parallel restoring divider lanes that share the three
  // window divisors, min(fill, window) times the interval scale. A zero
  // divisor forces its averages to zero.
  wtrm_dp #(
    .RING_DEPTH     (RING_DEPTH),
    .INTERVAL_SCALE (INTERVAL_SCALE)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_sent_bytes      (in_sent_bytes),
    .in_recv_bytes      (in_recv_bytes),
    .out_avg_sent_short (out_avg_sent_short),
    .out_avg_sent_mid   (out_avg_sent_mid),
    .out_avg_sent_long  (out_avg_sent_long),
    .out_avg_recv_short (out_avg_recv_short),
    .out_avg_recv_mid   (out_avg_recv_mid),
    .out_avg_recv_long  (out_avg_recv_long),
    .out_peak_sent      (out_peak_sent),
    .out_peak_recv      (out_peak_recv),
    .out_peak_total     (out_peak_total)
  );

endmodule

`default_nettype wire
